FILE: rtl/core/rule_conflict_free_grouping_defines.svh
// ----------------------------------------------------------------------------
// Rule conflict-free grouping: assertion macros
// Shared assertion forms for the checker of the grouping block.
// ----------------------------------------------------------------------------
`ifndef RULE_CONFLICT_FREE_GROUPING_DEFINES_SVH
`define RULE_CONFLICT_FREE_GROUPING_DEFINES_SVH

// Same-cycle implication, checked only out of reset.
`define RCFG_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only out of reset.
`define RCFG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/rcfg_pkg.sv
// ----------------------------------------------------------------------------
// Rule conflict-free grouping package
// Shared constants, key mode codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package rcfg_pkg;

    // Default table sizes.
    localparam int MaxEntriesDef = 256;
    localparam int MaxGroupsDef  = 64;

    // Fixed field widths.
    localparam int AddrW     = 32;
    localparam int PortW     = 16;
    localparam int KeyModeW  = 2;
    localparam int GrpIdxW   = 6;
    localparam int GrpTotW   = 7;
    localparam int ApbAddrW  = 2;
    localparam int ApbDataW  = 32;

    // Clash test selected by the key mode register.
    localparam logic [KeyModeW-1:0] KEY_PAIR = 2'd0;
    localparam logic [KeyModeW-1:0] KEY_SRC  = 2'd1;
    localparam logic [KeyModeW-1:0] KEY_DST  = 2'd2;
    localparam logic [KeyModeW-1:0] KEY_PORT = 2'd3;

    // Item operation codes.
    localparam logic MODE_ASSIGN = 1'b0;
    localparam logic MODE_CLEAR  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // latch a new item and clear the clash marks
        logic clear;      // empty the table and group list
        logic mark_full;  // drop the rule, flag the table as full
        logic rd_en;      // read the next stored entry
        logic step;       // move on to the next group
        logic commit;     // place the rule in the current group
        logic out_load;   // present the result on the output register
    } rcfg_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_clear;     // latched item is a clear item
        logic entry_full;   // no entry space left
        logic entry_empty;  // no stored entries to scan
        logic scan_last;    // current read is the last stored entry
        logic grp_end;      // group pointer has passed every open group
        logic grp_fit;      // current group has no clash with the rule
        logic grp_full;     // no room to open another group
        logic out_free;     // output register can take a new item
    } rcfg_status_t;

endpackage

FILE: rtl/core/rcfg_ctrl.sv
// ----------------------------------------------------------------------------
// Rule conflict-free grouping controller
// Sequences one item: a clear or a drop, or an entry scan, group search and commit, then the result hand-off.
// ----------------------------------------------------------------------------
module rcfg_ctrl
    import rcfg_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  rcfg_status_t status,
    output rcfg_cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_CHECK  = 6'b000010,
        ST_SCAN   = 6'b000100,
        ST_DRAIN  = 6'b001000,
        ST_SEARCH = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.is_clear) begin
                    cmd.clear  = 1'b1;
                    state_next = ST_DONE;
                end else if (status.entry_full) begin
                    cmd.mark_full = 1'b1;
                    state_next    = ST_DONE;
                end else if (status.entry_empty) begin
                    state_next = ST_SEARCH;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.rd_en = 1'b1;
                if (status.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // The last read word updates the clash marks in this cycle.
                state_next = ST_SEARCH;
            end
            ST_SEARCH: begin
                if (status.grp_end) begin
                    if (status.grp_full) begin
                        cmd.mark_full = 1'b1;
                    end else begin
                        cmd.commit = 1'b1;
                    end
                    state_next = ST_DONE;
                end else if (status.grp_fit) begin
                    cmd.commit = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/rcfg_datapath.sv
// ----------------------------------------------------------------------------
// Rule conflict-free grouping datapath
// Entry memory, per-group clash marks, counters and the output register.
// ----------------------------------------------------------------------------
module rcfg_datapath
    import rcfg_pkg::*;
#(
    parameter int MAX_ENTRIES = MaxEntriesDef,
    parameter int MAX_GROUPS  = MaxGroupsDef
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [KeyModeW-1:0]  key_mode,
    input  logic                 s_mode,
    input  logic [AddrW-1:0]     s_src_addr,
    input  logic [AddrW-1:0]     s_dst_addr,
    input  logic [PortW-1:0]     s_dst_port,
    input  rcfg_cmd_t            cmd,
    output rcfg_status_t         status,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [GrpIdxW-1:0]   m_group_index,
    output logic                 m_opened_group,
    output logic                 m_table_full,
    output logic [GrpTotW-1:0]   m_group_total
);

    localparam int EIW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int ECW = $clog2(MAX_ENTRIES + 1);
    localparam int GW  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int GCW = $clog2(MAX_GROUPS + 1);
    localparam int EW  = 2 * AddrW + PortW + GW;

    // Latched item.
    logic                 mode_reg;
    logic [AddrW-1:0]     src_reg;
    logic [AddrW-1:0]     dst_reg;
    logic [PortW-1:0]     port_reg;

    // Table state.
    logic [EW-1:0]        mem [MAX_ENTRIES];
    logic [ECW-1:0]       entry_count_reg;
    logic [GCW-1:0]       group_count_reg;

    // Scan and search pointers.
    logic [EIW-1:0]       idx_reg;
    logic [GCW-1:0]       grp_reg;
    logic [EW-1:0]        rd_data_reg;
    logic                 rd_vld_reg;

    // Clash marks, one bit per group and key.
    logic [MAX_GROUPS-1:0] seen_src_reg;
    logic [MAX_GROUPS-1:0] seen_dst_reg;
    logic [MAX_GROUPS-1:0] seen_port_reg;

    // Result being built.
    logic [GW-1:0]        res_grp_reg;
    logic                 res_opened_reg;
    logic                 res_full_reg;

    // Output register.
    logic                 m_valid_reg;
    logic [GrpIdxW-1:0]   m_group_index_reg;
    logic                 m_opened_group_reg;
    logic                 m_table_full_reg;
    logic [GrpTotW-1:0]   m_group_total_reg;

    // Read word fields.
    logic [AddrW-1:0]     rd_src;
    logic [AddrW-1:0]     rd_dst;
    logic [PortW-1:0]     rd_port;
    logic [GW-1:0]        rd_grp;
    logic [GW-1:0]        grp_sel;
    logic                 fit;
    logic                 out_free;
    logic [GW+GrpIdxW-1:0]  grp_ext;
    logic [GCW+GrpTotW-1:0] tot_ext;

    assign rd_src  = rd_data_reg[EW-1 -: AddrW];
    assign rd_dst  = rd_data_reg[EW-AddrW-1 -: AddrW];
    assign rd_port = rd_data_reg[GW +: PortW];
    assign rd_grp  = rd_data_reg[GW-1:0];
    assign grp_sel = grp_reg[GW-1:0];

    // Group fit test under the current key mode.
    always_comb begin
        case (key_mode)
            KEY_PAIR: fit = !(seen_src_reg[grp_sel] && seen_dst_reg[grp_sel]);
            KEY_SRC:  fit = !seen_src_reg[grp_sel];
            KEY_DST:  fit = !seen_dst_reg[grp_sel];
            KEY_PORT: fit = !seen_port_reg[grp_sel];
            default:  fit = 1'b0;
        endcase
    end

    assign out_free = !m_valid_reg || m_ready;

    // Status to the controller.
    always_comb begin
        status             = '0;
        status.is_clear    = (mode_reg == MODE_CLEAR);
        status.entry_full  = (entry_count_reg == ECW'(MAX_ENTRIES));
        status.entry_empty = (entry_count_reg == '0);
        status.scan_last   = ((ECW'(idx_reg) + ECW'(1)) == entry_count_reg);
        status.grp_end     = (grp_reg == group_count_reg);
        status.grp_fit     = fit;
        status.grp_full    = (group_count_reg == GCW'(MAX_GROUPS));
        status.out_free    = out_free;
    end

    // Item latch.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg <= s_mode;
            src_reg  <= s_src_addr;
            dst_reg  <= s_dst_addr;
            port_reg <= s_dst_port;
        end
    end

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            mem[entry_count_reg[EIW-1:0]] <= {src_reg, dst_reg, port_reg, grp_sel};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    // Scan pointer and read valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.rd_en;
            if (cmd.load) begin
                idx_reg <= '0;
            end else if (cmd.rd_en) begin
                idx_reg <= idx_reg + EIW'(1);
            end
        end
    end

    // Clash marks: cleared per item, set from each stored entry.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            seen_src_reg  <= '0;
            seen_dst_reg  <= '0;
            seen_port_reg <= '0;
        end else if (rd_vld_reg) begin
            if (rd_src == src_reg) begin
                seen_src_reg[rd_grp] <= 1'b1;
            end
            if (rd_dst == dst_reg) begin
                seen_dst_reg[rd_grp] <= 1'b1;
            end
            if (rd_port == port_reg) begin
                seen_port_reg[rd_grp] <= 1'b1;
            end
        end
    end

    // Group search pointer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grp_reg <= '0;
        end else if (cmd.load) begin
            grp_reg <= '0;
        end else if (cmd.step) begin
            grp_reg <= grp_reg + GCW'(1);
        end
    end

    // Table counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= '0;
            group_count_reg <= '0;
        end else if (cmd.clear) begin
            entry_count_reg <= '0;
            group_count_reg <= '0;
        end else if (cmd.commit) begin
            entry_count_reg <= entry_count_reg + ECW'(1);
            if (status.grp_end) begin
                group_count_reg <= group_count_reg + GCW'(1);
            end
        end
    end

    // Result fields for the item in progress.
    always_ff @(posedge aclk) begin
        if (cmd.clear || cmd.mark_full) begin
            res_grp_reg    <= '0;
            res_opened_reg <= 1'b0;
            res_full_reg   <= cmd.mark_full;
        end else if (cmd.commit) begin
            res_grp_reg    <= grp_sel;
            res_opened_reg <= status.grp_end;
            res_full_reg   <= 1'b0;
        end
    end

    // Group index and total are masked to their field widths.
    assign grp_ext = {{GrpIdxW{1'b0}}, res_grp_reg};
    assign tot_ext = {{GrpTotW{1'b0}}, group_count_reg};

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_group_index_reg  <= grp_ext[GrpIdxW-1:0];
            m_opened_group_reg <= res_opened_reg;
            m_table_full_reg   <= res_full_reg;
            m_group_total_reg  <= tot_ext[GrpTotW-1:0];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_group_index  = m_group_index_reg;
    assign m_opened_group = m_opened_group_reg;
    assign m_table_full   = m_table_full_reg;
    assign m_group_total  = m_group_total_reg;

endmodule

FILE: rtl/core/rule_conflict_free_grouping.sv
// ----------------------------------------------------------------------------
// Rule conflict-free grouping
// First-fit placement of exact-match rule keys into clash-free groups.
// ----------------------------------------------------------------------------
// Usage:
// Each input item carries one rule key (source address, destination address,
// destination port) and a mode bit; mode 0 places the rule, mode 1 empties
// the table. Every item yields exactly one result item carrying the group
// index, an opened-group flag, a table-full flag and the group total.
// The key_mode register at byte address 0 selects the clash test; the user
// must write it through the APB port only while the block is idle, which
// the block itself does not enforce.
// A clear item or a drop on a full entry table goes straight to the result.
// A placement reads the stored entries through the single read port of the
// entry memory, one entry per cycle, lets the last read word update the
// clash marks, then searches the groups, one group per cycle, and commits
// to the first group that fits or to a newly opened one, or drops the rule
// when the group list is full; an empty table skips the scan and the drain.
// One item is in work at a time; the next item is taken from the cycle after
// the result is loaded.
// After reset the table and group list are empty and key_mode is 0.
// A result waits in the output register while the receiver stalls; the
// block takes the next item meanwhile but holds its next result until the
// register frees.
// ----------------------------------------------------------------------------
module rule_conflict_free_grouping
    import rcfg_pkg::*;
#(
    parameter int MAX_ENTRIES = MaxEntriesDef,
    parameter int MAX_GROUPS  = MaxGroupsDef
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ApbAddrW-1:0]  paddr,
    input  logic [ApbDataW-1:0]  pwdata,
    output logic [ApbDataW-1:0]  prdata,
    output logic                 pready,
    // Input channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_mode,
    input  logic [AddrW-1:0]     s_src_addr,
    input  logic [AddrW-1:0]     s_dst_addr,
    input  logic [PortW-1:0]     s_dst_port,
    // Result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [GrpIdxW-1:0]   m_group_index,
    output logic                 m_opened_group,
    output logic                 m_table_full,
    output logic [GrpTotW-1:0]   m_group_total
);

    logic [KeyModeW-1:0] key_mode_reg;
    logic                cfg_wr;
    rcfg_cmd_t           cmd;
    rcfg_status_t        status;

    // The single register is written at address 0 and read back at every address.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == '0);
    assign prdata = {{(ApbDataW-KeyModeW){1'b0}}, key_mode_reg};

    // Key mode register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_mode_reg <= KEY_PAIR;
        end else if (cfg_wr) begin
            key_mode_reg <= pwdata[KeyModeW-1:0];
        end
    end

    // Sequencer.
    rcfg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Table, clash marks and output register.
    rcfg_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .MAX_GROUPS  (MAX_GROUPS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .key_mode       (key_mode_reg),
        .s_mode         (s_mode),
        .s_src_addr     (s_src_addr),
        .s_dst_addr     (s_dst_addr),
        .s_dst_port     (s_dst_port),
        .cmd            (cmd),
        .status         (status),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_group_index  (m_group_index),
        .m_opened_group (m_opened_group),
        .m_table_full   (m_table_full),
        .m_group_total  (m_group_total)
    );

endmodule

FILE: rtl/core/rcfg_checker.sv
// ----------------------------------------------------------------------------
// Rule conflict-free grouping checker
// Port-level checks on the result channel and the item sequencing.
// ----------------------------------------------------------------------------
`include "rule_conflict_free_grouping_defines.svh"

module rcfg_checker
    import rcfg_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [GrpIdxW-1:0] m_group_index,
    input logic               m_opened_group,
    input logic               m_table_full,
    input logic [GrpTotW-1:0] m_group_total
);

    // A stalled result holds its value.
    `RCFG_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_group_index) && $stable(m_group_total) && $stable(m_table_full), "result changed while stalled")

    // A dropped rule reports group zero and opens nothing.
    `RCFG_ASSERT_NOW(a_full_zero, aclk, aresetn, m_valid && m_table_full, (m_group_index == '0) && !m_opened_group, "dropped rule reports a group")

    // A newly opened group is always the highest one in use.
    `RCFG_ASSERT_NOW(a_open_total, aclk, aresetn, m_valid && m_opened_group, m_group_total[GrpIdxW-1:0] == (m_group_index + GrpIdxW'(1)), "opened group is not the last one")

    // Only one item is in work at a time.
    `RCFG_ASSERT_NEXT(a_busy, aclk, aresetn, s_valid && s_ready, !s_ready, "second item taken while busy")

endmodule

bind rule_conflict_free_grouping rcfg_checker u_rcfg_checker (.*);
